FILE: src/xor_lcg_string_hash_mod_core_assert.svh
// Assertion macros for the checker file.
`ifndef XOR_LCG_STRING_HASH_MOD_CORE_ASSERT_SVH
`define XOR_LCG_STRING_HASH_MOD_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define XLSH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define XLSH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/xlsh_pkg.sv
package xlsh_pkg;

    localparam int HASH_W    = 32;
    localparam int MOD_W     = 31;
    localparam int BYTE_W    = 8;
    localparam int DIV_CNT_W = $clog2(HASH_W);

    localparam logic [HASH_W-1:0] LCG_MULT = 32'd1664525;
    localparam logic [HASH_W-1:0] LCG_ADD  = 32'd1013904223;
    localparam logic [MOD_W-1:0]  MOD_RESET = 31'd1;

    typedef struct packed {
        logic              push;
        logic [HASH_W-1:0] hash;
    } t_q_wr;

    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
    } t_q_rd;

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_DIV  = 3'b010,
        BK_HOLD = 3'b100
    } t_bk_state;

endpackage

FILE: src/xlsh_front.sv
module xlsh_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [xlsh_pkg::BYTE_W-1:0] i_char_byte,
    input  logic                        i_has_char,
    input  logic                        i_is_last,
    input  logic                        i_q_full,
    output logic                        o_full,
    output xlsh_pkg::t_q_wr             o_q_wr
);
    import xlsh_pkg::*;

    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] n_hash;
    logic [HASH_W-1:0] w_ext;
    logic [HASH_W-1:0] w_mixed;
    logic [HASH_W-1:0] w_final;
    logic              w_accept;

    assign o_full   = i_q_full;
    assign w_accept = i_push && !i_q_full;
    assign w_ext    = {{(HASH_W-BYTE_W){i_char_byte[BYTE_W-1]}}, i_char_byte};
    assign w_mixed  = (r_hash ^ w_ext) * LCG_MULT + LCG_ADD;
    assign w_final  = i_has_char ? w_mixed : r_hash;

    always_comb begin
        n_hash = r_hash;
        if (w_accept) begin
            n_hash = i_is_last ? '0 : w_final;
        end
    end

    assign o_q_wr.push = w_accept && i_is_last;
    assign o_q_wr.hash = w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else begin
            r_hash <= n_hash;
        end
    end

endmodule

FILE: src/xlsh_fifo.sv
module xlsh_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  xlsh_pkg::t_q_wr i_wr,
    input  logic            i_pop,
    output logic            o_full,
    output xlsh_pkg::t_q_rd o_rd
);
    import xlsh_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [HASH_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              w_wr;
    logic              w_rd;

    assign o_full      = (r_cnt == CW'(DEPTH));
    assign o_rd.valid  = (r_cnt != '0);
    assign o_rd.hash   = r_mem[r_rd_ptr];
    assign w_wr        = i_wr.push && !o_full;
    assign w_rd        = i_pop && o_rd.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr.hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

endmodule

FILE: src/xlsh_back.sv
module xlsh_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  xlsh_pkg::t_q_rd            i_q_rd,
    input  logic [xlsh_pkg::MOD_W-1:0] i_modulus,
    input  logic                       pop,
    output logic                       o_q_pop,
    output logic                       empty,
    output logic [xlsh_pkg::MOD_W-1:0] o_bucket_index
);
    import xlsh_pkg::*;

    t_bk_state            r_state, n_state;
    logic [HASH_W-1:0]    r_quo, n_quo;
    logic [HASH_W-1:0]    r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [MOD_W-1:0]     r_out, n_out;
    logic                 r_out_vld, n_out_vld;
    logic [HASH_W-1:0]    w_mod;
    logic [HASH_W-1:0]    w_trial;
    logic                 w_out_take;

    assign w_mod      = {1'b0, (i_modulus == '0) ? MOD_W'(1) : i_modulus};
    assign w_trial    = {r_rem[HASH_W-2:0], r_quo[HASH_W-1]};
    assign w_out_take = pop && r_out_vld;
    assign empty      = !r_out_vld;
    assign o_bucket_index = r_out;

    always_comb begin
        n_state   = r_state;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_out     = r_out;
        n_out_vld = r_out_vld && !w_out_take;
        o_q_pop   = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_q_rd.valid) begin
                    o_q_pop = 1'b1;
                    n_quo   = i_q_rd.hash;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                n_quo = {r_quo[HASH_W-2:0], 1'b0};
                n_rem = (w_trial >= w_mod) ? w_trial - w_mod : w_trial;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(HASH_W - 1)) begin
                    n_state = BK_HOLD;
                end
            end
            BK_HOLD: begin
                if (!r_out_vld || w_out_take) begin
                    n_out     = r_rem[MOD_W-1:0];
                    n_out_vld = 1'b1;
                    n_state   = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_out <= n_out;
        r_cnt <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

FILE: src/xor_lcg_string_hash_mod_core.sv
// Streaming string hash, one byte per transaction. The front end mixes one byte per cycle
// through a single 32x32 multiply-add, so bytes are taken every cycle while the hand-off
// queue (QUEUE_DEPTH entries) has room. Each string's final hash is reduced by a restoring
// divider, one quotient bit per cycle. It takes a new string only after it has handed
// its result to the output register; long strings can run at one byte per cycle, while
// a stream of short strings is bounded by the divider. The modulus may be written only
// while no string is in flight; 0 behaves as 1.
module xor_lcg_string_hash_mod_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [xlsh_pkg::MOD_W-1:0]  i_cfg_wdata,
    input  logic                        push,
    output logic                        full,
    input  logic [xlsh_pkg::BYTE_W-1:0] i_char_byte,
    input  logic                        i_has_char,
    input  logic                        i_is_last,
    output logic                        empty,
    input  logic                        pop,
    output logic [xlsh_pkg::MOD_W-1:0]  o_bucket_index
);
    import xlsh_pkg::*;

    logic [MOD_W-1:0] r_modulus, n_modulus;
    t_q_wr            w_q_wr;
    t_q_rd            w_q_rd;
    logic             w_q_full;
    logic             w_q_pop;

    always_comb begin
        n_modulus = r_modulus;
        if (i_cfg_we) begin
            n_modulus = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_RESET;
        end else begin
            r_modulus <= n_modulus;
        end
    end

    xlsh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_char_byte (i_char_byte),
        .i_has_char  (i_has_char),
        .i_is_last   (i_is_last),
        .i_q_full    (w_q_full),
        .o_full      (full),
        .o_q_wr      (w_q_wr)
    );

    xlsh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_rd    (w_q_rd)
    );

    xlsh_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_rd         (w_q_rd),
        .i_modulus      (r_modulus),
        .pop            (pop),
        .o_q_pop        (w_q_pop),
        .empty          (empty),
        .o_bucket_index (o_bucket_index)
    );

endmodule

FILE: src/xlsh_chk.sv
`include "xor_lcg_string_hash_mod_core_assert.svh"

module xlsh_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cfg_we,
    input logic [xlsh_pkg::MOD_W-1:0]  i_cfg_wdata,
    input logic                        push,
    input logic                        full,
    input logic [xlsh_pkg::BYTE_W-1:0] i_char_byte,
    input logic                        i_has_char,
    input logic                        i_is_last,
    input logic                        empty,
    input logic                        pop,
    input logic [xlsh_pkg::MOD_W-1:0]  o_bucket_index
);
    import xlsh_pkg::*;

    logic [MOD_W-1:0] r_mod;
    logic [7:0]       r_pend;
    logic             w_inc;
    logic             w_dec;
    logic             w_stall;
    logic             w_idx_ok;

    assign w_inc    = push && !full && i_is_last;
    assign w_dec    = pop && !empty;
    assign w_stall  = !empty && !pop;
    assign w_idx_ok = (o_bucket_index < r_mod) || (r_mod == '0 && o_bucket_index == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod  <= MOD_RESET;
            r_pend <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mod <= i_cfg_wdata;
            end
            if (w_inc && !w_dec) begin
                r_pend <= r_pend + 1'b1;
            end else if (w_dec && !w_inc) begin
                r_pend <= r_pend - 1'b1;
            end
        end
    end

    `XLSH_ASSERT_NXT(a_out_hold, w_stall, !empty && $stable(o_bucket_index), "result not held")
    `XLSH_ASSERT_IMP(a_idx_range, !empty, w_idx_ok, "bucket index not below modulus")
    `XLSH_ASSERT_IMP(a_no_orphan, !empty, r_pend != '0, "result without a terminated string")
    `XLSH_ASSERT_IMP(a_reset_state, $past(!i_rst_n), empty && !full, "not clear after reset")

endmodule

bind xor_lcg_string_hash_mod_core xlsh_chk u_chk (.*);
